// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro wraps one concurrent assertion with a clock and an async reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`endif

// ----- src/lbf_pkg.sv -----
// Types and constants for the LED brightness fade engine.
// No dependencies.
package lbf_pkg;
	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_SET   = 3'd1,
		ACT_PULSE = 3'd2,
		ACT_FADE  = 3'd3,
		ACT_CYCLE = 3'd4,
		ACT_STOP  = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SINE,
		ST_MUL,
		ST_OUT
	} state_t;

	// Input transfer: one command or one millisecond tick.
	typedef struct packed {
		action_t action;
		logic [7:0] level;
		logic [7:0] peak_level;
		logic [23:0] duration_ms;
	} cmd_item_t;

	// Output transfer: the level report for one item.
	typedef struct packed {
		logic [7:0] brightness;
		logic changed;
		logic done_res;
		logic busy_res;
	} level_report_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // take the accepted item, do the command work
		logic div_step; // one restoring division step
		logic sine;     // look up sine and form the weight
		logic mul;      // form the blended level
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_calc; // item was a tick that needs a new level
		logic div_last;  // division is on its final step
	} stat_t;

	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned Q_W = 16;
endpackage

// ----- src/lbf_if.sv -----
// Valid/ready channel interface for the fade engine.
// Payload width is a type parameter; no package dependency.
interface lbf_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/lbf_ctrl.sv -----
// Controller state machine of the fade engine.
// Depends on lbf_pkg.
module lbf_ctrl import lbf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV;
			ST_DIV: begin
				if (!stat.need_calc) state_d = ST_OUT;
				else if (stat.div_last) state_d = ST_SINE;
			end
			ST_SINE: state_d = ST_MUL;
			ST_MUL:  state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV:  cmd.div_step = stat.need_calc;
			ST_SINE: cmd.sine = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

// ----- src/lbf_dp.sv -----
// Datapath of the fade engine: state registers, divider, sine table, blend.
// Depends on lbf_pkg.
module lbf_dp import lbf_pkg::*; #(
	parameter int unsigned TIME_BITS = 24,
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [2:0]  action,
	input  logic [7:0]  level,
	input  logic [7:0]  peak_level,
	input  logic [23:0] duration_ms,
	output logic [7:0]  brightness,
	output logic        changed,
	output logic        done_res,
	output logic        busy_res
);
	localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH) + 1;
	localparam int unsigned DIV_W = TIME_BITS + Q_W;
	localparam int unsigned CNT_W = $clog2(DIV_W + 1);
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	logic [7:0] cur_q, start_q, targ_q, base_q, peak_q;
	logic [TIME_BITS-1:0] elap_q, total_q;
	logic run_q, lin_q, cyc_q, chg_q, done_q, calc_q;
	logic [DIV_W-1:0] num_q, quo_q;
	logic [TIME_BITS:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [16:0] w_q;
	logic [TIME_BITS-1:0] dur_t, elap_inc;

	assign dur_t = TIME_BITS'(duration_ms);
	assign elap_inc = (elap_q == TMAX) ? elap_q : elap_q + 1'b1;

	// Sine table entry i = sin(i/DEPTH * pi/2) in Q0.16, built from the series.
	function automatic logic [15:0] rom(input int unsigned i);
		logic [63:0] x, x2, term, r;
		longint sum;
		x = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		r = (64'(sum) + 64'd8192) >> 14;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	logic [15:0] sine_tab [SINE_TABLE_DEPTH+1];
	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		assign sine_tab[g] = rom(g);
	end

	// Phase selection and quarter-wave lookup.
	logic [15:0] p16, phase, sv;
	logic [IDX_W-1:0] idx, ridx;
	logic [13+IDX_W:0] prod_i;
	assign p16 = quo_q[15:0];
	assign phase = lin_q ? p16 : (cyc_q ? {1'b0, p16[15:1]} : p16 - 16'd16384);
	assign prod_i = (14+IDX_W)'(phase[13:0]) * (14+IDX_W)'(SINE_TABLE_DEPTH);
	assign idx = prod_i[13+IDX_W:14];
	assign ridx = phase[14] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
	assign sv = sine_tab[ridx];

	// Blend from the selected origin toward the selected end.
	logic [7:0] from_l, to_l, mag_a, mag8;
	logic neg;
	logic [24:0] mprod;
	assign from_l = cyc_q ? base_q : start_q;
	assign to_l = cyc_q ? peak_q : targ_q;
	assign neg = to_l < from_l;
	assign mag_a = neg ? from_l - to_l : to_l - from_l;
	assign mprod = 25'(mag_a) * 25'(w_q);
	assign mag8 = mprod[23:16];

	// Divider remainder trial.
	logic [TIME_BITS:0] rtry;
	assign rtry = {rem_q[TIME_BITS-1:0], num_q[DIV_W-1]};

	assign stat.need_calc = calc_q;
	assign stat.div_last = (cnt_q == CNT_W'(DIV_W - 1));
	assign brightness = cur_q;
	assign changed = chg_q;
	assign done_res = done_q;
	assign busy_res = run_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= 8'd128; start_q <= 8'd128; targ_q <= 8'd128;
			base_q <= 8'd128; peak_q <= 8'd255;
			elap_q <= '0; total_q <= '0;
			run_q <= 1'b0; lin_q <= 1'b0; cyc_q <= 1'b0;
			chg_q <= 1'b0; done_q <= 1'b0; calc_q <= 1'b0;
		end else if (cmd.load) begin
			chg_q <= 1'b0; done_q <= 1'b0; calc_q <= 1'b0;
			case (action)
				ACT_TICK: if (run_q) begin
					elap_q <= elap_inc;
					if (elap_inc >= total_q) begin
						if (cyc_q) begin
							cur_q <= base_q;
							cyc_q <= 1'b0;
						end else if (lin_q) cur_q <= targ_q;
						run_q <= 1'b0;
						done_q <= 1'b1;
					end else calc_q <= 1'b1;
				end
				ACT_SET: begin
					chg_q <= (level != cur_q) && !run_q;
					cur_q <= level;
				end
				ACT_PULSE, ACT_FADE: begin
					targ_q <= level; start_q <= cur_q; total_q <= dur_t;
					elap_q <= '0; run_q <= 1'b1;
					lin_q <= (action == ACT_FADE);
				end
				ACT_CYCLE: begin
					cyc_q <= 1'b1; base_q <= level; peak_q <= peak_level;
					total_q <= dur_t; chg_q <= (level != cur_q); cur_q <= level;
					elap_q <= '0; start_q <= level; targ_q <= peak_level;
					run_q <= 1'b1; lin_q <= 1'b0;
				end
				ACT_STOP: begin
					run_q <= 1'b0; cyc_q <= 1'b0;
				end
				default: ;
			endcase
		end else if (cmd.mul) begin
			cur_q <= neg ? from_l - mag8 : from_l + mag8;
		end
	end

	// Restoring divider, one quotient bit per cycle, and weight register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			w_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			num_q <= {elap_inc, {Q_W{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
			num_q <= num_q << 1;
			if (rtry >= {1'b0, total_q}) begin
				rem_q <= rtry - {1'b0, total_q};
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rtry;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end else if (cmd.sine) begin
			if (lin_q) w_q <= {1'b0, p16};
			else if (cyc_q) w_q <= {1'b0, sv};
			else if (phase[15]) w_q <= 17'((17'd65535 - 17'(sv)) >> 1);
			else w_q <= 17'((17'd65535 + 17'(sv)) >> 1);
		end
	end
endmodule

// ----- src/led_brightness_fade_pulse_engine_core.sv -----
// Top level of the LED brightness fade and pulse engine.
// Depends on lbf_pkg, lbf_if, lbf_ctrl and lbf_dp.
//
// One result per item. A command, an idle tick or a completing tick passes
// from acceptance through the divide state straight to the result state; a tick
// that moves the level runs the one-bit-per-cycle divider that forms elapsed
// over duration (TIME_BITS + 16 steps), then the sine lookup and then the blend
// multiply. The result is held until taken, and the next item is accepted the
// cycle after that.
module led_brightness_fade_pulse_engine_core import lbf_pkg::*; #(
	parameter int unsigned TIME_BITS = 24,
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	lbf_if.sink   in_ch,
	lbf_if.source out_ch
);
	cmd_t  cmd;
	stat_t stat;

	lbf_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat, .cmd
	);

	lbf_dp #(.TIME_BITS(TIME_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.action(in_ch.data.action), .level(in_ch.data.level),
		.peak_level(in_ch.data.peak_level), .duration_ms(in_ch.data.duration_ms),
		.brightness(out_ch.data.brightness), .changed(out_ch.data.changed),
		.done_res(out_ch.data.done_res), .busy_res(out_ch.data.busy_res)
	);
endmodule

// ----- src/lbf_chk.sv -----
// Port checker for the fade engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module lbf_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic done_res,
	input logic busy_res,
	input logic changed
);
	// No input is taken while a result waits.
	`ASSERT_CLK(a_no_overlap, clk, arst_n, out_valid |-> !in_ready)
	// A completion leaves the engine idle.
	`ASSERT_CLK(a_done_idle, clk, arst_n, (out_valid && done_res) |-> !busy_res)
	// A result stays until it is taken.
	`ASSERT_CLK(a_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid)
	// Done and changed never come together.
	`ASSERT_CLK(a_excl, clk, arst_n, out_valid |-> !(done_res && changed))
endmodule

bind led_brightness_fade_pulse_engine_core lbf_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.done_res(out_ch.data.done_res), .busy_res(out_ch.data.busy_res),
	.changed(out_ch.data.changed)
);
